@@ rtl/urc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// urc_pkg
// Shared types and constants for the ultrasonic ranging controller.
// ============================================================================
package urc_pkg;

    // Echo duration counter width (valid range 12..32).
    localparam int ECHO_COUNT_BITS = 16;
    localparam int DIV_CNT_BITS    = $clog2(ECHO_COUNT_BITS);
    localparam int CMP_BITS        = (ECHO_COUNT_BITS > 16) ? ECHO_COUNT_BITS : 16;

    localparam int ELAPSED_BITS = 20;
    localparam int DIST_BITS    = 16;

    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = 24;
    localparam int M_TUSER_BITS = 2;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // Register reset values
    localparam logic [19:0] PING_INTERVAL_RST = 20'd60000;
    localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd30000;
    localparam logic [7:0]  CM_DIVISOR_RST    = 8'd58;
    localparam logic [7:0]  TRIGGER_HIGH_RST  = 8'd10;
    localparam logic [15:0] ERROR_VALUE_RST   = 16'hFFFF;

    // Register word index (byte address / 4)
    typedef enum logic [2:0] {
        REG_PING_INTERVAL = 3'd0,
        REG_ECHO_TIMEOUT  = 3'd1,
        REG_CM_DIVISOR    = 3'd2,
        REG_TRIGGER_HIGH  = 3'd3,
        REG_ERROR_VALUE   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [19:0] ping_interval_us;
        logic [15:0] echo_timeout_us;
        logic [7:0]  cm_divisor;
        logic [7:0]  trigger_high_us;
        logic [15:0] error_value;
    } cfg_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } state_t;

endpackage : urc_pkg
`default_nettype wire

@@ rtl/urc_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// urc_regs
// APB-style configuration register file.
// ============================================================================
module urc_regs
    import urc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output cfg_t                          cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ping_interval_us <= PING_INTERVAL_RST;
            cfg_reg.echo_timeout_us  <= ECHO_TIMEOUT_RST;
            cfg_reg.cm_divisor       <= CM_DIVISOR_RST;
            cfg_reg.trigger_high_us  <= TRIGGER_HIGH_RST;
            cfg_reg.error_value      <= ERROR_VALUE_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_PING_INTERVAL: cfg_reg.ping_interval_us <= pwdata[19:0];
                REG_ECHO_TIMEOUT:  cfg_reg.echo_timeout_us  <= pwdata[15:0];
                REG_CM_DIVISOR:    cfg_reg.cm_divisor       <= pwdata[7:0];
                REG_TRIGGER_HIGH:  cfg_reg.trigger_high_us  <= pwdata[7:0];
                REG_ERROR_VALUE:   cfg_reg.error_value      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PING_INTERVAL: prdata = APB_DATA_BITS'(cfg_reg.ping_interval_us);
            REG_ECHO_TIMEOUT:  prdata = APB_DATA_BITS'(cfg_reg.echo_timeout_us);
            REG_CM_DIVISOR:    prdata = APB_DATA_BITS'(cfg_reg.cm_divisor);
            REG_TRIGGER_HIGH:  prdata = APB_DATA_BITS'(cfg_reg.trigger_high_us);
            REG_ERROR_VALUE:   prdata = APB_DATA_BITS'(cfg_reg.error_value);
            default:           prdata = '0;
        endcase
    end

endmodule : urc_regs
`default_nettype wire

@@ rtl/urc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// urc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ============================================================================
module urc_div
    import urc_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [ECHO_COUNT_BITS-1:0] dividend,
    input  wire logic [7:0]                 divisor,
    output logic                            busy,
    output logic      [ECHO_COUNT_BITS-1:0] quotient
);

    logic                       busy_reg;
    logic [DIV_CNT_BITS-1:0]    cnt_reg;
    logic [7:0]                 rem_reg;
    logic [7:0]                 rem_next;
    logic [7:0]                 dsr_reg;
    logic [ECHO_COUNT_BITS-1:0] quo_reg;
    logic [8:0]                 rem_sh;
    logic                       ge;

    // Shift in the next dividend bit, subtract if it fits
    assign rem_sh   = {rem_reg, quo_reg[ECHO_COUNT_BITS-1]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_next = ge ? 8'(rem_sh - {1'b0, dsr_reg}) : rem_sh[7:0];

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == DIV_CNT_BITS'(ECHO_COUNT_BITS - 1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[ECHO_COUNT_BITS-2:0], ge};
        end
    end

endmodule : urc_div
`default_nettype wire

@@ rtl/ultrasonic_ranging_controller_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ultrasonic_ranging_controller_core
// Ping scheduler and echo timer for an HC-SR04 style ranging sensor.
// ============================================================================
//
//  channel   direction  fields (low bit first)
//  -------   ---------  ---------------------------------------------------
//  s_        in         tdata: echo_level, zero pad to 8 bits
//  m_        out        tdata: trigger_level, distance_cm[15:0], zero pad
//                       tuser: new_reading, timed_out
//  apb       cfg        ping_interval_us @0x00, echo_timeout_us @0x04,
//                       cm_divisor @0x08, trigger_high_us @0x0C,
//                       error_value @0x10
//
//  One transaction per microsecond tick in, one out. A tick that needs no
//  divide loads the output register as it is accepted. A tick that closes
//  an echo pulse with a valid duration and a nonzero cm_divisor runs the
//  serial divider: the accept cycle, one quotient bit per cycle, and the
//  publish cycle, which waits until the output register is free.
//  s_tready is low while the divider runs or the output register is full
//  and not being drained. Reset is synchronous, active low, and restores
//  register defaults and clears all measurement state.
//
// ============================================================================
module ultrasonic_ranging_controller_core
    import urc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // input stream
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_BITS-1:0]  s_tdata,   // [0] echo_level
    // result stream
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [M_TDATA_BITS-1:0]  m_tdata,   // [0] trigger_level, [16:1] distance_cm
    output logic      [M_TUSER_BITS-1:0]  m_tuser,   // [0] new_reading, [1] timed_out
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    cfg_t cfg;

    urc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [ELAPSED_BITS-1:0]    ping_elapsed_reg, ping_elapsed_next;
    logic [ECHO_COUNT_BITS-1:0] echo_count_reg, echo_count_next;
    logic                       measuring_reg, measuring_next;
    logic                       echo_prev_reg, echo_prev_next;
    logic [7:0]                 trig_rem_reg, trig_rem_next;
    logic [DIST_BITS-1:0]       dist_hold_reg, dist_hold_next;
    logic                       trig_pend_reg, trig_pend_next;

    // output register
    logic                       m_tvalid_reg;
    logic                       trig_out_reg;
    logic [DIST_BITS-1:0]       dist_out_reg;
    logic                       fresh_out_reg;
    logic                       tout_out_reg;

    logic                       out_load;
    logic                       out_trig;
    logic                       out_fresh;
    logic                       out_tout;

    // divider
    logic                       div_start;
    logic                       div_busy;
    logic [ECHO_COUNT_BITS-1:0] div_quotient;

    logic out_free;
    logic accept;
    logic echo;
    logic rise;
    logic fall;
    logic dur_bad;
    logic ping;
    logic [ELAPSED_BITS-1:0] elapsed_inc;

    urc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (echo_count_reg),
        .divisor  (cfg.cm_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign echo = s_tdata[0];
    assign rise = echo && !echo_prev_reg;
    assign fall = !echo && echo_prev_reg;

    // zero duration or at/over timeout is an error reading
    assign dur_bad = (echo_count_reg == '0) ||
                     (CMP_BITS'(echo_count_reg) >= CMP_BITS'(cfg.echo_timeout_us));

    // saturating tick counter; ping when it passes the interval
    assign elapsed_inc = (ping_elapsed_reg != '1) ? ping_elapsed_reg + 1'b1 : ping_elapsed_reg;
    assign ping        = elapsed_inc > cfg.ping_interval_us;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        ping_elapsed_next = ping_elapsed_reg;
        echo_count_next   = echo_count_reg;
        measuring_next    = measuring_reg;
        echo_prev_next    = echo_prev_reg;
        trig_rem_next     = trig_rem_reg;
        dist_hold_next    = dist_hold_reg;
        trig_pend_next    = trig_pend_reg;
        div_start         = 1'b0;
        out_load          = 1'b0;
        out_trig          = 1'b0;
        out_fresh         = 1'b0;
        out_tout          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // falling edge closes the measurement
                    if (measuring_reg && fall) begin
                        measuring_next = 1'b0;
                        out_fresh      = 1'b1;
                        if (dur_bad) begin
                            dist_hold_next = cfg.error_value;
                        end else if (cfg.cm_divisor == '0) begin
                            dist_hold_next = '1;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end else if (measuring_reg && echo) begin
                        if (echo_count_reg != '1) begin
                            echo_count_next = echo_count_reg + 1'b1;
                        end
                    end

                    // ping schedule
                    ping_elapsed_next = elapsed_inc;
                    if (ping) begin
                        ping_elapsed_next = '0;
                        if (measuring_next) begin
                            measuring_next = 1'b0;
                            dist_hold_next = cfg.error_value;
                            out_tout       = 1'b1;
                            out_fresh      = 1'b1;
                        end
                        trig_rem_next = cfg.trigger_high_us;
                    end

                    if (rise) begin
                        measuring_next  = 1'b1;
                        echo_count_next = ECHO_COUNT_BITS'(1);
                    end
                    echo_prev_next = echo;

                    // trigger pin
                    out_trig = trig_rem_next != '0;
                    if (out_trig) begin
                        trig_rem_next = trig_rem_next - 1'b1;
                    end
                    trig_pend_next = out_trig;

                    // divide path publishes later from ST_DIV
                    out_load = !div_start;
                end
            end
            ST_DIV: begin
                if (!div_busy && out_free) begin
                    dist_hold_next = DIST_BITS'(div_quotient);
                    out_load       = 1'b1;
                    out_trig       = trig_pend_reg;
                    out_fresh      = 1'b1;
                    out_tout       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ping_elapsed_reg <= '0;
            echo_count_reg   <= '0;
            measuring_reg    <= 1'b0;
            echo_prev_reg    <= 1'b0;
            trig_rem_reg     <= '0;
            dist_hold_reg    <= '0;
            trig_pend_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            ping_elapsed_reg <= ping_elapsed_next;
            echo_count_reg   <= echo_count_next;
            measuring_reg    <= measuring_next;
            echo_prev_reg    <= echo_prev_next;
            trig_rem_reg     <= trig_rem_next;
            dist_hold_reg    <= dist_hold_next;
            trig_pend_reg    <= trig_pend_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            trig_out_reg  <= out_trig;
            dist_out_reg  <= dist_hold_next;
            fresh_out_reg <= out_fresh;
            tout_out_reg  <= out_tout;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_BITS - DIST_BITS - 1){1'b0}}, dist_out_reg, trig_out_reg};
    assign m_tuser  = {tout_out_reg, fresh_out_reg};

endmodule : ultrasonic_ranging_controller_core
`default_nettype wire

@@ bench/ultrasonic_ranging_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ultrasonic_ranging_checker
// Passive monitor for the ranging core. It tracks register writes on the
// APB port and every echo tick taken in, predicts the result transaction for
// each tick, and compares the predictions in order against the m_ stream.
// ============================================================================
module ultrasonic_ranging_checker
    import urc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [S_TDATA_BITS-1:0]  s_tdata,   // [0] echo_level
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [M_TDATA_BITS-1:0]  m_tdata,   // [0] trigger_level, [16:1] distance_cm
    input  wire logic [M_TUSER_BITS-1:0]  m_tuser,   // [0] new_reading, [1] timed_out
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic                     pready,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    input  wire logic                     end_of_test,
    output int unsigned                   mismatches
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic                 timed_out;
        logic                 new_reading;
        logic [DIST_BITS-1:0] distance_cm;
        logic                 trigger_level;
    } tick_result_t;

    // shadow registers and measurement state
    cfg_t                       regs;
    logic [ELAPSED_BITS-1:0]    since_ping;
    logic [ECHO_COUNT_BITS-1:0] high_ticks;
    logic                       timing;
    logic                       echo_last;
    logic [7:0]                 trig_left;
    logic [DIST_BITS-1:0]       held_cm;
    tick_result_t               due_results[$];
    logic                       leftover_checked;

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [DIST_BITS-1:0] echo_to_cm(input logic [ECHO_COUNT_BITS-1:0] ticks);
        if (ticks == '0 || ticks >= regs.echo_timeout_us)
            return regs.error_value;
        if (regs.cm_divisor == '0)
            return '1;
        return DIST_BITS'(ticks / regs.cm_divisor);
    endfunction

    // one microsecond tick: falling edge, ping schedule, rising edge, trigger
    task automatic advance_tick(input logic echo, output tick_result_t r);
        logic rise;
        logic fall;
        rise = echo && !echo_last;
        fall = !echo && echo_last;
        r = '0;
        if (timing && fall) begin
            held_cm = echo_to_cm(high_ticks);
            timing = 1'b0;
            r.new_reading = 1'b1;
        end else if (timing && echo && high_ticks != '1) begin
            high_ticks++;
        end
        if (since_ping != '1)
            since_ping++;
        if (since_ping > regs.ping_interval_us) begin
            since_ping = '0;
            if (timing) begin
                timing = 1'b0;
                held_cm = regs.error_value;
                r.timed_out = 1'b1;
                r.new_reading = 1'b1;
            end
            trig_left = regs.trigger_high_us;
        end
        if (rise) begin
            timing = 1'b1;
            high_ticks = ECHO_COUNT_BITS'(1);
        end
        echo_last = echo;
        r.trigger_level = (trig_left != '0);
        if (trig_left != '0)
            trig_left--;
        r.distance_cm = held_cm;
    endtask

    always @(posedge aclk) begin : watch
        tick_result_t got;
        tick_result_t want;
        if (!aresetn) begin
            regs = '{ping_interval_us: PING_INTERVAL_RST, echo_timeout_us: ECHO_TIMEOUT_RST,
                     cm_divisor: CM_DIVISOR_RST, trigger_high_us: TRIGGER_HIGH_RST,
                     error_value: ERROR_VALUE_RST};
            since_ping = '0;
            high_ticks = '0;
            timing = 1'b0;
            echo_last = 1'b0;
            trig_left = '0;
            held_cm = '0;
            due_results.delete();
            leftover_checked = 1'b0;
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_ADDR_BITS-1:2]))
                    REG_PING_INTERVAL: regs.ping_interval_us = pwdata[19:0];
                    REG_ECHO_TIMEOUT:  regs.echo_timeout_us  = pwdata[15:0];
                    REG_CM_DIVISOR:    regs.cm_divisor       = pwdata[7:0];
                    REG_TRIGGER_HIGH:  regs.trigger_high_us  = pwdata[7:0];
                    REG_ERROR_VALUE:   regs.error_value      = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser[1], m_tuser[0], m_tdata[16:1], m_tdata[0]};
                if (due_results.size() == 0) begin
                    report("result with no tick pending", 1, 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.trigger_level != want.trigger_level)
                        report("trigger_level", got.trigger_level, want.trigger_level);
                    if (got.distance_cm != want.distance_cm)
                        report("distance_cm", got.distance_cm, want.distance_cm);
                    if (got.new_reading != want.new_reading)
                        report("new_reading", got.new_reading, want.new_reading);
                    if (got.timed_out != want.timed_out)
                        report("timed_out", got.timed_out, want.timed_out);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_tick(s_tdata[0], want);
                due_results.push_back(want);
            end
            if (end_of_test && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (due_results.size() != 0)
                    report("results never returned", due_results.size(), 0);
            end
        end
    end

endmodule

@@ bench/tb_ultrasonic_ranging_controller_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_ultrasonic_ranging_controller_core
// Drives echo ticks and register settings into the ranging core, throttles
// both stream sides at random, and leaves prediction and comparison to the
// checker instance. Gives the final verdict.
// ============================================================================
module tb_ultrasonic_ranging_controller_core
    import urc_pkg::*;
();

    localparam int STALL_LIMIT   = 3000;                // cycles with no transaction at all
    localparam int SETTLE_CYCLES = ECHO_COUNT_BITS + 4; // time for a running divide, plus margin
    localparam int HOLD_CYCLES   = 400;                 // long back-pressure burst
    localparam int IDLE_PERCENT  = 22;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata;   // [0] echo_level, rest zero
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;   // [0] trigger_level, [16:1] distance_cm
    logic [M_TUSER_BITS-1:0]  m_tuser;   // [0] new_reading, [1] timed_out
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     end_of_test;

    int unsigned mismatches;
    int unsigned ticks_in;       // input transactions taken by the core
    int unsigned results_out;    // result transactions taken from the core
    int unsigned stall_cycles;
    int unsigned hold_requests = 0;
    int unsigned hold_served;
    bit          steady = 1'b0;  // set: neither side inserts idle cycles

    ultrasonic_ranging_controller_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ultrasonic_ranging_checker range_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .end_of_test (end_of_test),
        .mismatches  (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Transaction counters and the watchdog. The watchdog only trips when
    // the idle run of both streams reaches STALL_LIMIT; every legal pause
    // here (hold-off burst, divider, register writes) is far shorter.
    always @(posedge aclk) begin
        if (!aresetn) begin
            ticks_in     <= 0;
            results_out  <= 0;
            stall_cycles <= 0;
        end else begin
            if (s_tvalid && s_tready)
                ticks_in <= ticks_in + 1;
            if (m_tvalid && m_tready)
                results_out <= results_out + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Result side: random back-pressure, plus a long hold-off burst whenever
    // the stimulus asks for one. The burst is counted here so the sender
    // keeps offering ticks meanwhile and the core has to stall its input.
    initial begin : result_sink
        int unsigned hold_left;
        hold_left   = 0;
        hold_served = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Offer one echo tick, with random idle cycles ahead of it, and return
    // right after the edge that takes it. s_tvalid stays high on return so
    // back-to-back ticks see no bubble.
    task automatic send_tick(input logic echo);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'(echo);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_run(input logic echo, input int unsigned n);
        repeat (n) send_tick(echo);
    endtask

    // Bit 0 goes first.
    task automatic send_pattern(input logic [31:0] bits, input int unsigned n);
        for (int i = 0; i < n; i++)
            send_tick(bits[i]);
    endtask

    // Sender stops and waits until every tick has its result back.
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_out != ticks_in);
    endtask

    // APB write: setup, access, then psel dropped before return, so that
    // back-to-back writes never assign the same signal twice in one step.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Registers change only with the core idle: drained, then given time
    // for a divide that could still be running.
    task automatic load_settings(input logic [19:0] interval, input logic [15:0] timeout,
                                 input logic [7:0] divisor, input logic [7:0] trig_width,
                                 input logic [15:0] err_value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_PING_INTERVAL, APB_DATA_BITS'(interval));
        write_reg(REG_ECHO_TIMEOUT,  APB_DATA_BITS'(timeout));
        write_reg(REG_CM_DIVISOR,    APB_DATA_BITS'(divisor));
        write_reg(REG_TRIGGER_HIGH,  APB_DATA_BITS'(trig_width));
        write_reg(REG_ERROR_VALUE,   APB_DATA_BITS'(err_value));
    endtask

    // Mostly clean echo pulses (low gap, then high pulse) of random length;
    // the rest is short bursts of random levels. Optionally fires one
    // hold-off burst a third of the way in, or a full drain half way.
    task automatic random_echo(input int unsigned n_ticks, input int unsigned max_high,
                               input int unsigned max_low, input bit hold_midway,
                               input bit drain_midway);
        int unsigned sent;
        int unsigned run_lo;
        int unsigned run_hi;
        int unsigned noise;
        bit          hold_done;
        bit          drain_done;
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (sent < n_ticks) begin
            if (hold_midway && !hold_done && sent >= n_ticks / 3) begin
                hold_requests++;
                hold_done = 1'b1;
            end
            if (drain_midway && !drain_done && sent >= n_ticks / 2) begin
                wait_drained();
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) begin
                run_lo = $urandom_range(1, max_low);
                run_hi = $urandom_range(1, max_high);
                send_run(1'b0, run_lo);
                send_run(1'b1, run_hi);
                sent += run_lo + run_hi;
            end else begin
                noise = $urandom_range(1, 8);
                repeat (noise) send_tick(1'($urandom_range(0, 1)));
                sent += noise;
            end
        end
    endtask

    initial begin : stimulus
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        end_of_test <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: short pulses give distance 0, no ping yet.
        send_pattern(32'b011010, 6);

        // Tight schedule: a 1-tick echo (valid), a 3-tick echo at the timeout
        // (error value), a long echo cut off by a ping (timed out), then its
        // falling edge arriving with nothing open, which must be ignored.
        load_settings(20'd4, 16'd3, 8'd1, 8'd2, 16'hABCD);
        send_pattern(32'b000111111011101, 15);

        // Divide by one, zero error value; one long hold-off on the results.
        load_settings(20'd60, 16'd25, 8'd1, 8'd5, 16'h0000);
        random_echo(200, 30, 30, 1'b1, 1'b0);

        // Ping every tick: any echo still open is closed right away.
        load_settings(20'd0, 16'd20, 8'd255, 8'd1, 16'hFFFF);
        random_echo(120, 8, 4, 1'b0, 1'b0);

        // Ping every other tick with the widest trigger: pulse keeps restarting.
        load_settings(20'd1, 16'd65535, 8'd7, 8'd255, 16'h5A5A);
        random_echo(120, 40, 6, 1'b0, 1'b0);

        // Zero timeout, zero divisor, zero trigger width.
        load_settings(20'd30, 16'd0, 8'd0, 8'd0, 16'h8001);
        random_echo(120, 12, 10, 1'b0, 1'b0);

        // Timeout of one: every duration lands on the error value.
        load_settings(20'd100, 16'd1, 8'd13, 8'd10, 16'h7FFF);
        random_echo(120, 5, 5, 1'b0, 1'b0);

        // Interval near the top of its range, long echoes, no idle cycles on either side.
        load_settings(20'd1000000, 16'd65535, 8'd2, 8'd255, 16'h1234);
        steady = 1'b1;
        random_echo(200, 300, 20, 1'b0, 1'b0);
        steady = 1'b0;

        // Large quotients and a drain pause in the middle.
        load_settings(20'd255, 16'd1000, 8'd1, 8'd1, 16'hFFFE);
        random_echo(300, 400, 100, 1'b0, 1'b1);

        // Random settings: interval 20..400, timeout 2..300, other registers full range.
        repeat (2) begin
            load_settings(20'($urandom_range(20, 400)), 16'($urandom_range(2, 300)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          16'($urandom));
            random_echo(150, 160, 100, 1'b0, 1'b0);
        end

        // Interval at all ones never pings: two valid echoes under the
        // widest timeout with nothing to cut them off.
        load_settings(20'hFFFFF, 16'd65535, 8'd1, 8'd255, 16'hCAFE);
        send_run(1'b0, 2);
        send_run(1'b1, 40);
        send_run(1'b0, 2);
        send_run(1'b1, 25);
        send_run(1'b0, 2);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/urc_pkg.sv
rtl/urc_regs.sv
rtl/urc_div.sv
rtl/ultrasonic_ranging_controller_core.sv
bench/ultrasonic_ranging_checker.sv
bench/tb_ultrasonic_ranging_controller_core.sv
